// ----- rtl/tsls_pkg.sv -----
// ---------------------------------------------------------------------------
// tsls_pkg: shared types and constants for the two-species life stepper
// Cell codes, register indexes and the payload structs of both channels.
// ---------------------------------------------------------------------------
package tsls_pkg;

  // Cell codes
  localparam logic [1:0] CELL_EMPTY = 2'd0;
  localparam logic [1:0] CELL_ONE   = 2'd1;
  localparam logic [1:0] CELL_TWO   = 2'd2;
  localparam logic [1:0] CELL_THREE = 2'd3;

  // Configuration port
  localparam int CFG_W       = 11;
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 2'd1;
  localparam logic [CFG_W-1:0]       COUNT_RESET      = 11'd1024;
  localparam int                     COUNT_MIN        = 3;

  // Neighbour totals that keep or give birth
  localparam logic [3:0] KEEP_LOW  = 4'd2;
  localparam logic [3:0] KEEP_HIGH = 4'd3;

  typedef struct packed {
    logic [1:0] cell_state;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [1:0] new_state;
    logic [9:0] out_row;
    logic [9:0] out_column;
    logic       frame_last;
  } out_item_t;

endpackage

// ----- rtl/two_species_life_stepper_core.sv -----
// ---------------------------------------------------------------------------
// two_species_life_stepper_core: one Life generation with two species
// Raster cell stream in, interior cell updates out, two line stores held
// in one read-modify-write memory and a 3x3 window of registers.
// ---------------------------------------------------------------------------
// Result path: the transfer of the cell that completes a window starts the
//   line store read and loads stage B; window and rule feed the output register.
// Throughput: one cell per cycle while output is not blocked; line store
//   read at accept, write-back when stage B advances, forwarding between them.
// Reset: positions, window and handshake state clear; counts go to 1024;
//   line store contents stay undefined until written, no clearing pass.
module two_species_life_stepper_core
  import tsls_pkg::*;
#(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int CW  = $clog2(MAX_COLUMNS);
  localparam int RW  = $clog2(MAX_ROWS);
  // Compare widths: wide enough for the raw register and for the maximum
  localparam int CCW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int RCW = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

  // Configuration registers
  logic [CFG_W-1:0] row_count;
  logic [CFG_W-1:0] column_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= COUNT_RESET;
      column_count <= COUNT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROW_COUNT:    row_count    <= cfg_data;
        REG_COLUMN_COUNT: column_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp counts into their legal range
  logic [RCW-1:0] rows;
  logic [CCW-1:0] cols;
  logic [RCW-1:0] row_raw;
  logic [CCW-1:0] col_raw;

  always_comb begin
    row_raw = RCW'(row_count);
    col_raw = CCW'(column_count);
    if (row_raw < RCW'(COUNT_MIN))       rows = RCW'(COUNT_MIN);
    else if (row_raw > RCW'(MAX_ROWS))   rows = RCW'(MAX_ROWS);
    else                                 rows = row_raw;
    if (col_raw < CCW'(COUNT_MIN))       cols = CCW'(COUNT_MIN);
    else if (col_raw > CCW'(MAX_COLUMNS)) cols = CCW'(MAX_COLUMNS);
    else                                 cols = col_raw;
  end

  // Raster position
  logic [RW-1:0]  row_position;
  logic [CW-1:0]  column_position;
  logic [RW-1:0]  row_position_next;
  logic [CW-1:0]  column_position_next;
  logic [RCW-1:0] cur_row;
  logic [CCW-1:0] cur_col;
  logic           cur_emit;
  logic           cur_last;

  // Pipeline control
  logic in_fire;
  logic b_valid;
  logic b_adv;
  logic b_emit;

  assign in_fire = in_valid && in_ready;

  // Normalise the position, apply frame start, then step it
  always_comb begin
    cur_row = RCW'(row_position);
    cur_col = CCW'(column_position);
    if (cur_col >= cols) begin
      cur_col = '0;
      cur_row = cur_row + RCW'(1);
    end
    if (cur_row >= rows) cur_row = '0;
    if (in_data.frame_start) begin
      cur_row = '0;
      cur_col = '0;
    end
    cur_emit = (cur_row >= RCW'(2)) && (cur_col >= CCW'(2));
    cur_last = (cur_row == rows - RCW'(1)) && (cur_col == cols - CCW'(1));
    if (cur_col + CCW'(1) >= cols) begin
      column_position_next = '0;
      row_position_next    = (cur_row + RCW'(1) >= rows) ? '0 : RW'(cur_row + RCW'(1));
    end else begin
      column_position_next = CW'(cur_col + CCW'(1));
      row_position_next    = RW'(cur_row);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_position    <= '0;
      column_position <= '0;
    end else if (in_fire) begin
      row_position    <= row_position_next;
      column_position <= column_position_next;
    end
  end

  // Line stores: upper in [3:2], middle in [1:0]
  logic [3:0]    line_mem [MAX_COLUMNS];
  logic [3:0]    rd_data;
  logic [CW-1:0] b_col;
  logic [1:0]    b_x;
  logic [9:0]    b_row_out;
  logic [9:0]    b_col_out;
  logic          b_last;
  logic          b_fwd;
  logic [3:0]    b_fwd_data;
  logic [3:0]    b_line;
  logic [3:0]    b_wr_data;
  logic [CW-1:0] rd_addr;

  assign rd_addr   = CW'(cur_col);
  assign b_line    = b_fwd ? b_fwd_data : rd_data;
  assign b_wr_data = {b_line[1:0], b_x};

  always_ff @(posedge clk) begin
    if (in_fire) rd_data <= line_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (b_valid && b_adv) line_mem[b_col] <= b_wr_data;
  end

  // Stage B: hold the item while its read is in flight or the output is blocked
  assign in_ready = !b_valid || b_adv;
  assign b_adv    = !b_emit || !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (in_fire) begin
      b_valid <= 1'b1;
    end else if (b_adv) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_col      <= rd_addr;
      b_x        <= in_data.cell_state;
      b_emit     <= cur_emit;
      b_last     <= cur_last;
      b_row_out  <= 10'(cur_row - RCW'(1));
      b_col_out  <= 10'(cur_col - CCW'(1));
      // Forward the write-back landing at the same edge on the same entry
      b_fwd      <= b_valid && b_adv && (b_col == rd_addr);
      b_fwd_data <= b_wr_data;
    end
  end

  // Window shift and the life rule
  logic [17:0] window_cells;
  logic [17:0] window_next;
  logic [3:0]  n1;
  logic [3:0]  n2;
  logic [3:0]  total;
  logic [1:0]  centre;
  logic [1:0]  rule_state;
  logic [1:0]  lane;

  always_comb begin
    window_next = {window_cells[11:0], b_x, b_line[1:0], b_line[3:2]};
    n1 = '0;
    n2 = '0;
    for (int i = 0; i < 9; i++) begin
      lane = window_next[2*i +: 2];
      if (i != 4) begin
        if (lane == CELL_ONE) n1 = n1 + 4'd1;
        else if (lane == CELL_TWO) n2 = n2 + 4'd1;
      end
    end
    total  = n1 + n2;
    centre = window_next[9:8];
    if (centre == CELL_THREE) centre = CELL_EMPTY;
    if (total < KEEP_LOW || total > KEEP_HIGH) rule_state = CELL_EMPTY;
    else if (centre != CELL_EMPTY)             rule_state = centre;
    else if (total == KEEP_HIGH)               rule_state = (n1 > n2) ? CELL_ONE : CELL_TWO;
    else                                       rule_state = CELL_EMPTY;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_cells <= '0;
    end else if (b_valid && b_adv) begin
      window_cells <= window_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_valid && b_adv && b_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid && b_adv && b_emit) begin
      out_data.new_state  <= rule_state;
      out_data.out_row    <= b_row_out;
      out_data.out_column <= b_col_out;
      out_data.frame_last <= b_last;
    end
  end

`ifndef ASSERT_OFF
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !b_valid |-> in_ready)
    else $error("input stalled with stage B empty");

  a_no_code_three: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.new_state != CELL_THREE)
    else $error("result carries cell code three");

  a_hold_blocked: assert property (@(posedge clk) disable iff (rst)
    b_valid && b_emit && out_valid && !out_ready |=> b_valid)
    else $error("blocked item dropped from stage B");

  a_fwd_match: assert property (@(posedge clk) disable iff (rst)
    in_fire && b_valid && b_adv && (b_col == rd_addr) |=> b_fwd)
    else $error("write-back to the same entry not forwarded");
`endif

endmodule

// ----- dv/tsls_stream_checker.sv -----
// ---------------------------------------------------------------------------
// tsls_stream_checker: prediction and comparison for the life stepper
// Watches the cell, update and register channels of the stepper, keeps its
// own line stores, window and raster position, and checks each update
// transfer field by field against the oldest predicted interior update.
// ---------------------------------------------------------------------------
module tsls_stream_checker
  import tsls_pkg::*;
#(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  in_item_t               in_data,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  out_item_t              out_data,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  output int                     mismatch_count,
  output int                     awaited_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the stepper state
  logic [1:0]       upper_line  [MAX_COLUMNS];
  logic [1:0]       middle_line [MAX_COLUMNS];
  logic [17:0]      window;
  int               row_pos;
  int               col_pos;
  logic [CFG_W-1:0] row_reg;
  logic [CFG_W-1:0] col_reg;
  out_item_t        pending_updates [$];

  // Limit a raw count register to the range the grid supports
  function automatic int clamp_extent(input logic [CFG_W-1:0] raw, input int ceiling);
    if (raw < COUNT_MIN) return COUNT_MIN;
    if (raw > ceiling) return ceiling;
    return int'(raw);
  endfunction

  // Apply the two-species rule to the centre of a 3x3 window
  function automatic logic [1:0] next_cell_state(input logic [17:0] win);
    int         n_one;
    int         n_two;
    int         total;
    logic [1:0] centre;
    logic [1:0] v;
    n_one = 0;
    n_two = 0;
    for (int j = 0; j < 9; j++) begin
      if (j != 4) begin
        v = win[2*j +: 2];
        if (v == CELL_ONE) n_one++;
        else if (v == CELL_TWO) n_two++;
      end
    end
    total  = n_one + n_two;
    centre = win[9:8];
    // a centre of value three behaves as empty
    if (centre == CELL_THREE) centre = CELL_EMPTY;
    if (total < KEEP_LOW || total > KEEP_HIGH) return CELL_EMPTY;
    if (centre != CELL_EMPTY) return centre;
    if (total == KEEP_HIGH) return (n_one > n_two) ? CELL_ONE : CELL_TWO;
    return CELL_EMPTY;
  endfunction

  // Advance the raster by one cell and queue the interior update it completes
  task automatic absorb_cell(input in_item_t item);
    int         rows;
    int         cols;
    int         r;
    int         c;
    logic [1:0] up;
    logic [1:0] mid;
    out_item_t  upd;
    rows = clamp_extent(row_reg, MAX_ROWS);
    cols = clamp_extent(col_reg, MAX_COLUMNS);
    // wrap a position left beyond the counts
    if (col_pos >= cols) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= rows) row_pos = 0;
    if (item.frame_start) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    // shift the column up through the line stores
    up  = upper_line[c];
    mid = middle_line[c];
    upper_line[c]  = mid;
    middle_line[c] = item.cell_state;
    window = {window[11:0], item.cell_state, mid, up};
    if (r >= 2 && c >= 2) begin
      upd.new_state  = next_cell_state(window);
      upd.out_row    = 10'(r - 1);
      upd.out_column = 10'(c - 1);
      upd.frame_last = (r == rows - 1) && (c == cols - 1);
      pending_updates.push_back(upd);
    end
    if (c + 1 >= cols) begin
      col_pos = 0;
      row_pos = (r + 1 >= rows) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // Compare one update transfer with the oldest prediction
  task automatic check_update(input out_item_t got);
    out_item_t want;
    if (pending_updates.size() == 0) begin
      $error("update with none predicted: row %0d column %0d", got.out_row, got.out_column);
      mismatch_count++;
    end else begin
      want = pending_updates.pop_front();
      if (got.new_state !== want.new_state) begin
        $error("new_state: expected %0d, actual %0d", want.new_state, got.new_state);
        mismatch_count++;
      end
      if (got.out_row !== want.out_row) begin
        $error("out_row: expected %0d, actual %0d", want.out_row, got.out_row);
        mismatch_count++;
      end
      if (got.out_column !== want.out_column) begin
        $error("out_column: expected %0d, actual %0d", want.out_column, got.out_column);
        mismatch_count++;
      end
      if (got.frame_last !== want.frame_last) begin
        $error("frame_last: expected %0d, actual %0d", want.frame_last, got.frame_last);
        mismatch_count++;
      end
    end
  endtask

  // Sample every channel at the rising edge; updates leave before new cells
  always @(posedge clk) begin
    if (rst) begin
      window  = '0;
      row_pos = 0;
      col_pos = 0;
      row_reg = COUNT_RESET;
      col_reg = COUNT_RESET;
      mismatch_count = 0;
      pending_updates.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROW_COUNT:    row_reg = cfg_data;
          REG_COLUMN_COUNT: col_reg = cfg_data;
          default: ;
        endcase
      end
      if (out_valid === 1'b1 && out_ready) check_update(out_data);
      if (in_valid && in_ready === 1'b1) absorb_cell(in_data);
    end
    awaited_count = pending_updates.size();
  end

endmodule

// ----- dv/two_species_life_stepper_core_tb.sv -----
// ---------------------------------------------------------------------------
// two_species_life_stepper_core_tb: stimulus and verdict for the stepper
// Feeds hand-built grids, then random grids of many sizes with bursty cells
// and a receiver that stalls; a checker beside the block predicts updates.
// ---------------------------------------------------------------------------
module two_species_life_stepper_core_tb;
  import tsls_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_ITEMS = 1750;
  localparam int PHASE_ITEMS  = 300;
  localparam int IDLE_GAP     = 8;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int MAX_COLUMNS  = 1024;
  localparam int MAX_ROWS     = 1024;

  // Register indexes with no register behind them
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

  // Hand-built grids, row-major, first cell in the top bits.
  // 3x4: a birth of species one and a survival past a neighbour of value three
  localparam logic [23:0] FIRST_GRID = {
    CELL_ONE,   CELL_EMPTY, CELL_EMPTY, CELL_THREE,
    CELL_ONE,   CELL_EMPTY, CELL_TWO,   CELL_ONE,
    CELL_THREE, CELL_EMPTY, CELL_EMPTY, CELL_TWO
  };
  // 4x4 cut short in row two: a centre of value three is born as species two
  localparam logic [23:0] WRAP_GRID = {
    2'b00,
    CELL_TWO,   CELL_TWO,   CELL_EMPTY, CELL_EMPTY,
    CELL_EMPTY, CELL_THREE, CELL_ONE,   CELL_EMPTY,
    CELL_EMPTY, CELL_EMPTY, CELL_EMPTY
  };

  typedef enum int {RX_ALWAYS, RX_HALF, RX_MOSTLY, RX_COMB, RX_SPARSE} rx_mode_e;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  in_item_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data  = '0;

  int   mismatches;
  int   awaited;
  logic hold_req    = 1'b0;
  int   burst_left  = 0;
  int   cycle_count = 0;

  always #CLK_HALF clk = ~clk;

  two_species_life_stepper_core #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tsls_stream_checker #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatches),
    .awaited_count  (awaited)
  );

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: stall in changing patterns, with one long hold-off on request
  initial begin
    rx_mode_e mode;
    int       mode_left;
    int       hold_left;
    int       tick;
    bit       hold_done;
    mode      = RX_ALWAYS;
    mode_left = 0;
    hold_left = 0;
    tick      = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        out_ready = 1'b0;
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(RX_ALWAYS, RX_SPARSE));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        tick++;
        case (mode)
          RX_ALWAYS: out_ready = 1'b1;
          RX_HALF:   out_ready = ($urandom_range(0, 1) == 1);
          RX_MOSTLY: out_ready = ($urandom_range(0, 99) < 85);
          RX_COMB:   out_ready = ((tick % 8) < 3);
          default:   out_ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic in_item_t make_cell(input logic [1:0] state, input logic start);
    in_item_t item;
    item.cell_state  = state;
    item.frame_start = start;
    return item;
  endfunction

  // Draw a cell: live at the given density, now and then three, else empty
  function automatic logic [1:0] random_cell(input int live_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return CELL_THREE;
    if (roll < 4 + live_pct) return $urandom_range(0, 1) ? CELL_TWO : CELL_ONE;
    return CELL_EMPTY;
  endfunction

  function automatic int effective_count(input logic [CFG_W-1:0] raw, input int ceiling);
    if (raw < COUNT_MIN) return COUNT_MIN;
    if (raw > ceiling) return ceiling;
    return int'(raw);
  endfunction

  // Offer one cell in bursts with random gaps; return at the falling edge
  // after its transfer, with valid still high
  task automatic offer_cell(input in_item_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid = 1'b1;
    in_data  = item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic offer_pattern(input logic [23:0] bits, input int count);
    for (int i = 0; i < count; i++) begin
      offer_cell(make_cell(bits[2*(count-1-i) +: 2], i == 0));
    end
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Drop valid, drain every predicted update, then let the pipe empty
  task automatic wait_until_idle();
    in_valid = 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (IDLE_GAP) @(negedge clk);
  endtask

  // Main sequence
  initial begin
    int               phase;
    int               small_items;
    int               items;
    int               frame;
    int               rows_e;
    int               cols_e;
    int               live_pct;
    logic [CFG_W-1:0] raw_rows;
    logic [CFG_W-1:0] raw_cols;
    bit               big;
    logic             start;

    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed: smallest sensible grids with hand-picked neighbourhoods
    write_register(REG_ROW_COUNT, 11'd3);
    write_register(REG_COLUMN_COUNT, 11'd4);
    offer_pattern(FIRST_GRID, 12);
    wait_until_idle();
    write_register(REG_ROW_COUNT, 11'd4);
    write_register(REG_COLUMN_COUNT, 11'd4);
    offer_pattern(WRAP_GRID, 11);
    wait_until_idle();
    // shrink both counts so that the current position wraps
    write_register(REG_COLUMN_COUNT, 11'd3);
    write_register(REG_ROW_COUNT, 11'd3);

    // Random: frames of many sizes, two of them at the largest extent in one direction
    phase       = 0;
    small_items = 0;
    while (small_items < RANDOM_ITEMS) begin
      big = 1'b0;
      case (phase)
        0: begin
          raw_rows = 11'd3;
          raw_cols = 11'd3;
        end
        2: begin
          raw_rows = '1;
          raw_cols = '0;
          big      = 1'b1;
        end
        5: begin
          raw_rows = 11'd1;
          raw_cols = 11'd1025;
          big      = 1'b1;
        end
        default: begin
          case ($urandom_range(0, 9))
            0:       raw_rows = CFG_W'($urandom_range(0, 2));
            1:       raw_rows = CFG_W'($urandom_range(13, 40));
            default: raw_rows = CFG_W'($urandom_range(3, 12));
          endcase
          case ($urandom_range(0, 9))
            0:       raw_cols = CFG_W'($urandom_range(0, 2));
            1:       raw_cols = CFG_W'($urandom_range(25, 64));
            default: raw_cols = CFG_W'($urandom_range(3, 24));
          endcase
        end
      endcase

      // the first phase keeps the counts and goes on from the wrapped position
      if (phase != 0) begin
        wait_until_idle();
        if (phase % 4 == 1) begin
          write_register($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                         CFG_W'($urandom));
        end
        write_register(REG_ROW_COUNT, raw_rows);
        write_register(REG_COLUMN_COUNT, raw_cols);
      end

      rows_e   = effective_count(raw_rows, MAX_ROWS);
      cols_e   = effective_count(raw_cols, MAX_COLUMNS);
      frame    = rows_e * cols_e;
      live_pct = $urandom_range(15, 60);
      if (big) begin
        items    = frame;
        hold_req = 1'b1;
      end else begin
        items = $urandom_range(1, 3) * frame;
        if ($urandom_range(0, 1)) items += $urandom_range(0, frame - 1);
      end
      // keep each phase short so that the run stays near its item budget
      if (items > PHASE_ITEMS) items = PHASE_ITEMS;

      for (int i = 0; i < items; i++) begin
        if (i == 0 && phase != 0) start = 1'b1;
        else if (i % frame == 0) start = ($urandom_range(0, 1) == 1);
        else start = !big && ($urandom_range(0, 199) == 0);
        offer_cell(make_cell(random_cell(live_pct), start));
      end
      small_items += items;
      phase++;
    end

    // Drain and give the verdict
    in_valid = 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && awaited == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
